// ----- hdl/scrc_pkg.sv -----
package scrc_pkg;

    localparam int SLOT_BITS_DEF   = 24;
    localparam int TOKEN_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Widths of the descriptor stream, the APB address and the APB data
    localparam int OUT_DATA_W = 112;
    localparam int ADDR_W     = 6;
    localparam int CFG_DATA_W = 64;

    localparam logic [12:0] SPT_RST = 13'd128;
    localparam logic [16:0] TPP_RST = 17'd1;
    localparam logic [7:0]  LC_RST  = 8'd1;
    localparam logic [24:0] PS_RST  = 25'd1;
    localparam logic [39:0] CTB_RST = 40'd0;
    localparam logic        DIR_RST = 1'b0;

    typedef enum logic [2:0] {
        REG_SPT = 3'd0,
        REG_TPP = 3'd1,
        REG_LC  = 3'd2,
        REG_PS  = 3'd3,
        REG_CTB = 3'd4,
        REG_DIR = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [12:0] scalars_per_token;
        logic [16:0] tokens_per_pass;
        logic [7:0]  layer_count;
        logic [24:0] page_slots;
        logic [39:0] cache_total_bytes;
        logic        to_paged;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- hdl/slot_run_copy_coalescer.sv -----
// Slot run copy coalescer.
// Input stream (s_*): one transfer per token of a pass. s_tdata carries the
// signed slot index (negative skips the token) and the layer, s_tuser the
// key/value half, s_tlast marks the last token of the pass.
// Output stream (m_*): one copy descriptor per closed run. m_tlast is set on
// the final descriptor that one input transfer causes.
// Configuration: APB port, 64-bit registers at byte address 8*i; pready is always
// high. The user writes them only while idle; the block does not enforce it.
// Throughput: the front takes one token per cycle while the descriptor queue
// has room; a token that closes two runs holds the input until both are queued.
// The back end steps each descriptor through B_TP, B_CACHE, B_PAGED, B_LEN and
// B_CHK with one shared multiplier and takes no new entry until it is back in
// B_IDLE, so it sets the sustained rate when runs are short.
// Reset clears the run tracker, the queue, the output register and loads the
// register defaults. A stalled receiver holds the output register, then the
// back end, then the queue fills and s_tready drops.
module slot_run_copy_coalescer
#(
    parameter int SLOT_BITS   = scrc_pkg::SLOT_BITS_DEF,
    parameter int TOKEN_BITS  = scrc_pkg::TOKEN_BITS_DEF,
    parameter int QUEUE_DEPTH = scrc_pkg::QUEUE_DEPTH_DEF,
    parameter int IN_W        = ((SLOT_BITS + 8 + 7) / 8) * 8
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [IN_W-1:0]                      s_tdata,   // slot_index, layer
    input  logic                                 s_tuser,   // kv_select
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // cache_offset, paged_offset, length_bytes, direction, bounds_error
    output logic [scrc_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [scrc_pkg::ADDR_W-1:0]          paddr,
    input  logic [scrc_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [scrc_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam int ENTRY_W = TOKEN_BITS + 2 * SLOT_BITS + 9;

    scrc_pkg::cfg_t    cfg;
    scrc_pkg::q_stat_t q_stat;
    logic              push;
    logic [ENTRY_W-1:0] push_data;
    logic              pop;
    logic [ENTRY_W-1:0] pop_data;

    assign pready = 1'b1;

    scrc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    scrc_front
    #(
        .SLOT_BITS  (SLOT_BITS),
        .TOKEN_BITS (TOKEN_BITS),
        .ENTRY_W    (ENTRY_W)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .slot_index (s_tdata[SLOT_BITS:0]),
        .layer      (s_tdata[SLOT_BITS+7:SLOT_BITS+1]),
        .kv_select  (s_tuser),
        .pass_end   (s_tlast),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    scrc_queue
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    scrc_back
    #(
        .SLOT_BITS  (SLOT_BITS),
        .TOKEN_BITS (TOKEN_BITS),
        .ENTRY_W    (ENTRY_W)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_data   (pop_data),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/scrc_cfg.sv -----
module scrc_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scrc_pkg::ADDR_W-1:0]       paddr,
    input  logic [scrc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [scrc_pkg::CFG_DATA_W-1:0]   prdata,
    output scrc_pkg::cfg_t                    cfg
);

    scrc_pkg::cfg_t     cfg_reg;
    scrc_pkg::reg_idx_t idx;
    logic               wr;

    assign idx = scrc_pkg::reg_idx_t'(paddr[5:3]);
    assign wr  = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scalars_per_token <= scrc_pkg::SPT_RST;
            cfg_reg.tokens_per_pass   <= scrc_pkg::TPP_RST;
            cfg_reg.layer_count       <= scrc_pkg::LC_RST;
            cfg_reg.page_slots        <= scrc_pkg::PS_RST;
            cfg_reg.cache_total_bytes <= scrc_pkg::CTB_RST;
            cfg_reg.to_paged          <= scrc_pkg::DIR_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                scrc_pkg::REG_SPT: cfg_reg.scalars_per_token <= pwdata[12:0];
                scrc_pkg::REG_TPP: cfg_reg.tokens_per_pass   <= pwdata[16:0];
                scrc_pkg::REG_LC:  cfg_reg.layer_count       <= pwdata[7:0];
                scrc_pkg::REG_PS:  cfg_reg.page_slots        <= pwdata[24:0];
                scrc_pkg::REG_CTB: cfg_reg.cache_total_bytes <= pwdata[39:0];
                scrc_pkg::REG_DIR: cfg_reg.to_paged          <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            scrc_pkg::REG_SPT: prdata = 64'(cfg_reg.scalars_per_token);
            scrc_pkg::REG_TPP: prdata = 64'(cfg_reg.tokens_per_pass);
            scrc_pkg::REG_LC:  prdata = 64'(cfg_reg.layer_count);
            scrc_pkg::REG_PS:  prdata = 64'(cfg_reg.page_slots);
            scrc_pkg::REG_CTB: prdata = 64'(cfg_reg.cache_total_bytes);
            scrc_pkg::REG_DIR: prdata = 64'(cfg_reg.to_paged);
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- hdl/scrc_front.sv -----
module scrc_front
#(
    parameter int SLOT_BITS  = scrc_pkg::SLOT_BITS_DEF,
    parameter int TOKEN_BITS = scrc_pkg::TOKEN_BITS_DEF,
    parameter int ENTRY_W    = TOKEN_BITS + 2 * SLOT_BITS + 9
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SLOT_BITS:0]   slot_index,
    input  logic [6:0]           layer,
    input  logic                 kv_select,
    input  logic                 pass_end,
    input  scrc_pkg::q_stat_t    q_stat,
    output logic                 push,
    output logic [ENTRY_W-1:0]   push_data
);

    logic [TOKEN_BITS:0]    tokcnt_reg,     tokcnt_next;
    logic [TOKEN_BITS-1:0]  start_tok_reg,  start_tok_next;
    logic [SLOT_BITS-1:0]   start_slot_reg, start_slot_next;
    logic [TOKEN_BITS-1:0]  last_tok_reg,   last_tok_next;
    logic [SLOT_BITS-1:0]   last_slot_reg,  last_slot_next;
    logic                   run_valid_reg,  run_valid_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [ENTRY_W-1:0]     pend_data_reg,  pend_data_next;

    logic                   acc;
    logic                   skip;
    logic [SLOT_BITS-1:0]   slot;
    logic [TOKEN_BITS-1:0]  tok;
    logic                   cont;
    logic                   brk;
    logic                   valid_after;
    logic                   emit_end;
    logic [ENTRY_W-2:0]     old_body;
    logic [ENTRY_W-2:0]     new_body;

    assign in_ready = !pend_valid_reg && !q_stat.full;
    assign acc      = in_valid && in_ready;
    assign skip     = slot_index[SLOT_BITS];
    assign slot     = slot_index[SLOT_BITS-1:0];
    assign tok      = tokcnt_reg[TOKEN_BITS-1:0];

    assign cont = (tok == last_tok_reg + TOKEN_BITS'(1)) &&
                  ({1'b0, slot} == {1'b0, last_slot_reg} + (SLOT_BITS + 1)'(1));
    assign brk  = !skip && run_valid_reg && !cont;

    always_comb
    begin
        start_tok_next  = start_tok_reg;
        start_slot_next = start_slot_reg;
        last_tok_next   = last_tok_reg;
        last_slot_next  = last_slot_reg;
        valid_after     = run_valid_reg;
        if (!skip)
        begin
            if (!run_valid_reg || brk)
            begin
                start_tok_next  = tok;
                start_slot_next = slot;
            end
            last_tok_next  = tok;
            last_slot_next = slot;
            valid_after    = 1'b1;
        end
    end

    assign emit_end = pass_end && valid_after;
    assign old_body = {kv_select, layer, last_slot_reg, start_slot_reg, start_tok_reg};
    assign new_body = {kv_select, layer, last_slot_next, start_slot_next, start_tok_next};

    always_comb
    begin
        push            = 1'b0;
        push_data       = pend_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        tokcnt_next     = tokcnt_reg;
        run_valid_next  = run_valid_reg;
        if (pend_valid_reg)
        begin
            push = !q_stat.full;
            if (!q_stat.full)
            begin
                pend_valid_next = 1'b0;
            end
        end
        else if (acc)
        begin
            // A break on the pass end item closes two runs: hold the second
            if (brk)
            begin
                push      = 1'b1;
                push_data = {!emit_end, old_body};
                if (emit_end)
                begin
                    pend_valid_next = 1'b1;
                    pend_data_next  = {1'b1, new_body};
                end
            end
            else if (emit_end)
            begin
                push      = 1'b1;
                push_data = {1'b1, new_body};
            end
        end
        if (acc)
        begin
            tokcnt_next    = pass_end ? '0 : tokcnt_reg + (TOKEN_BITS + 1)'(1);
            run_valid_next = pass_end ? 1'b0 : valid_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tokcnt_reg     <= '0;
            start_tok_reg  <= '0;
            start_slot_reg <= '0;
            last_tok_reg   <= '0;
            last_slot_reg  <= '0;
            run_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_data_reg  <= '0;
        end
        else
        begin
            tokcnt_reg     <= tokcnt_next;
            run_valid_reg  <= run_valid_next;
            pend_valid_reg <= pend_valid_next;
            pend_data_reg  <= pend_data_next;
            if (acc)
            begin
                start_tok_reg  <= start_tok_next;
                start_slot_reg <= start_slot_next;
                last_tok_reg   <= last_tok_next;
                last_slot_reg  <= last_slot_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_pass_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        acc && pass_end |=> tokcnt_reg == '0 && !run_valid_reg)
        else $error("pass end did not clear the run state");

    a_push_source: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> pend_valid_reg || acc)
        else $error("descriptor pushed without an item or a held entry");
`endif

endmodule

// ----- hdl/scrc_queue.sv -----
module scrc_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = scrc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   pop_data,
    output scrc_pkg::q_stat_t  q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("pop from an empty queue");
`endif

endmodule

// ----- hdl/scrc_back.sv -----
module scrc_back
#(
    parameter int SLOT_BITS  = scrc_pkg::SLOT_BITS_DEF,
    parameter int TOKEN_BITS = scrc_pkg::TOKEN_BITS_DEF,
    parameter int ENTRY_W    = TOKEN_BITS + 2 * SLOT_BITS + 9
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  scrc_pkg::cfg_t                       cfg,
    input  logic [ENTRY_W-1:0]                   q_data,
    input  scrc_pkg::q_stat_t                    q_stat,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [scrc_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tlast
);

    localparam int CW   = ((TOKEN_BITS > 26) ? TOKEN_BITS : 26) + 1;
    localparam int PW   = ((SLOT_BITS > 25) ? SLOT_BITS : 25) + 1;
    localparam int NW   = SLOT_BITS + 1;
    localparam int MA   = (CW > PW) ? CW : PW;
    localparam int PRW  = MA + 17;
    localparam int LENX = (NW + 14 > 33) ? NW + 14 : 33;
    localparam int SUMW = ((LENX > 41) ? LENX : 41) + 1;

    localparam int ST_LO = TOKEN_BITS;
    localparam int LS_LO = TOKEN_BITS + SLOT_BITS;
    localparam int LY_LO = TOKEN_BITS + 2 * SLOT_BITS;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TP,
        B_CACHE,
        B_PAGED,
        B_LEN,
        B_CHK
    } bstate_t;

    bstate_t                            state_reg,    state_next;
    logic [8:0]                         a_reg,        a_next;
    logic [TOKEN_BITS-1:0]              tok_reg,      tok_next;
    logic [PW-1:0]                      pbase_reg,    pbase_next;
    logic [NW-1:0]                      cnt_reg,      cnt_next;
    logic                               last_reg,     last_next;
    logic [CW-1:0]                      t_reg,        t_next;
    logic [39:0]                        cache_reg,    cache_next;
    logic [37:0]                        paged_reg,    paged_next;
    logic [LENX-1:0]                    len_reg,      len_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [scrc_pkg::OUT_DATA_W-1:0]    m_tdata_reg,  m_tdata_next;
    logic                               m_tlast_reg,  m_tlast_next;

    logic [TOKEN_BITS-1:0]  q_start_tok;
    logic [SLOT_BITS-1:0]   q_start_slot;
    logic [SLOT_BITS-1:0]   q_last_slot;
    logic [6:0]             q_layer;
    logic                   q_kv;
    logic                   q_last;

    logic [MA-1:0]          mul_a;
    logic [16:0]            mul_b;
    logic [PRW-1:0]         prod;
    logic [SUMW-1:0]        end_sum;
    logic                   sat;
    logic                   err;
    logic [31:0]            len_out;

    assign q_start_tok  = q_data[TOKEN_BITS-1:0];
    assign q_start_slot = q_data[LS_LO-1:ST_LO];
    assign q_last_slot  = q_data[LY_LO-1:LS_LO];
    assign q_layer      = q_data[LY_LO+6:LY_LO];
    assign q_kv         = q_data[LY_LO+7];
    assign q_last       = q_data[LY_LO+8];

    assign pop = (state_reg == B_IDLE) && !q_stat.empty;

    // One shared multiplier, one product per step
    always_comb
    begin
        case (state_reg)
            B_TP:
            begin
                mul_a = MA'(a_reg);
                mul_b = cfg.tokens_per_pass;
            end
            B_CACHE:
            begin
                mul_a = MA'(t_reg);
                mul_b = 17'(cfg.scalars_per_token);
            end
            B_PAGED:
            begin
                mul_a = MA'(pbase_reg);
                mul_b = 17'(cfg.scalars_per_token);
            end
            B_LEN:
            begin
                mul_a = MA'(cnt_reg);
                mul_b = 17'(cfg.scalars_per_token);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PRW'(mul_a) * PRW'(mul_b);

    assign end_sum = SUMW'({cache_reg, 1'b0}) + SUMW'(len_reg);
    assign sat     = len_reg > LENX'(33'h0_FFFF_FFFF);
    assign err     = sat || (end_sum > SUMW'(cfg.cache_total_bytes));
    assign len_out = sat ? 32'hFFFF_FFFF : len_reg[31:0];

    always_comb
    begin
        state_next    = state_reg;
        a_next        = a_reg;
        tok_next      = tok_reg;
        pbase_next    = pbase_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        t_next        = t_reg;
        cache_next    = cache_reg;
        paged_next    = paged_reg;
        len_next      = len_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    a_next     = q_kv ? 9'(cfg.layer_count) + 9'(q_layer) : 9'(q_layer);
                    tok_next   = q_start_tok;
                    pbase_next = q_kv ? PW'(cfg.page_slots) + PW'(q_start_slot)
                                      : PW'(q_start_slot);
                    cnt_next   = NW'(q_last_slot) - NW'(q_start_slot) + NW'(1);
                    last_next  = q_last;
                    state_next = B_TP;
                end
            end
            B_TP:
            begin
                t_next     = CW'(prod[25:0]) + CW'(tok_reg);
                state_next = B_CACHE;
            end
            B_CACHE:
            begin
                cache_next = prod[39:0];
                state_next = B_PAGED;
            end
            B_PAGED:
            begin
                paged_next = prod[37:0];
                state_next = B_LEN;
            end
            B_LEN:
            begin
                len_next   = LENX'({prod[NW+12:0], 1'b0});
                state_next = B_CHK;
            end
            B_CHK:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {err, cfg.to_paged, len_out, paged_reg, cache_reg};
                    m_tlast_next  = last_reg;
                    state_next    = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            a_reg        <= '0;
            tok_reg      <= '0;
            pbase_reg    <= '0;
            cnt_reg      <= '0;
            last_reg     <= 1'b0;
            t_reg        <= '0;
            cache_reg    <= '0;
            paged_reg    <= '0;
            len_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            a_reg        <= a_next;
            tok_reg      <= tok_next;
            pbase_reg    <= pbase_next;
            cnt_reg      <= cnt_next;
            last_reg     <= last_next;
            t_reg        <= t_next;
            cache_reg    <= cache_next;
            paged_reg    <= paged_next;
            len_reg      <= len_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    a_chk_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CHK && m_tvalid_reg && !m_tready |=> state_reg == B_CHK)
        else $error("descriptor finished while the output was stalled");

    a_valid_from_chk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == B_CHK))
        else $error("output raised outside the final step");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic        last_result;
        logic        bounds_error;
        logic        direction;
        logic [31:0] length_bytes;
        logic [37:0] paged_offset;
        logic [39:0] cache_offset;
    } copy_desc_t;

    typedef struct packed {
        logic [24:0] slot;
        logic [6:0]  layer;
        logic        kv;
        logic        pass_end;
        logic        typed;
        copy_desc_t  want;
    } token_step_t;

    localparam logic [24:0] SKIP    = '1;
    localparam copy_desc_t  NO_COPY = '0;

    // Register defaults: 128 scalars, one token, one layer, one page slot, no cache
    token_step_t directed_steps [16] = '{
        '{25'd5, 7'd0, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 32'd256, 38'd640, 40'd0}},
        '{SKIP, 7'd0, 1'b0, 1'b0, 1'b0, NO_COPY},
        '{25'd10, 7'd2, 1'b1, 1'b0, 1'b0, NO_COPY},
        '{25'd11, 7'd2, 1'b1, 1'b0, 1'b0, NO_COPY},
        '{25'd13, 7'd5, 1'b0, 1'b0, 1'b0, NO_COPY},
        '{SKIP, 7'd5, 1'b0, 1'b0, 1'b0, NO_COPY},
        '{25'd14, 7'd5, 1'b0, 1'b0, 1'b0, NO_COPY},
        '{25'd15, 7'd6, 1'b1, 1'b1, 1'b0, NO_COPY},
        '{25'd100, 7'd0, 1'b0, 1'b0, 1'b0, NO_COPY},
        '{25'd200, 7'd1, 1'b1, 1'b1, 1'b0, NO_COPY},
        '{SKIP, 7'd0, 1'b0, 1'b1, 1'b0, NO_COPY},
        '{25'hFFFFFF, 7'd127, 1'b1, 1'b0, 1'b0, NO_COPY},
        '{25'd0, 7'd127, 1'b1, 1'b1, 1'b0, NO_COPY},
        '{SKIP, 7'd0, 1'b0, 1'b0, 1'b0, NO_COPY},
        '{SKIP, 7'd0, 1'b0, 1'b0, 1'b0, NO_COPY},
        '{25'd7, 7'd1, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 32'd256, 38'd896, 40'd384}}
    };

    logic                                clk;
    logic                                rst_n    = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [31:0]                         s_tdata  = '0;    // slot_index[24:0], layer[31:25]
    logic                                s_tuser  = 1'b0;  // kv_select
    logic                                s_tlast  = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    // cache_offset[39:0], paged_offset[77:40], length_bytes[109:78],
    // direction[110], bounds_error[111]
    logic [scrc_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic                                m_tlast;
    logic                                psel     = 1'b0;
    logic                                penable  = 1'b0;
    logic                                pwrite   = 1'b0;
    logic [scrc_pkg::ADDR_W-1:0]         paddr    = '0;
    logic [scrc_pkg::CFG_DATA_W-1:0]     pwdata   = '0;
    logic [scrc_pkg::CFG_DATA_W-1:0]     prdata;
    logic                                pready;

    scrc_pkg::cfg_t shadow_cfg;
    copy_desc_t     pending_copies[$];
    copy_desc_t     closed_runs[2];
    int             mismatches = 0;
    int             cycles_run = 0;

    // Run tracker
    logic [16:0] tok_count;
    logic [15:0] run_tok0;
    logic [15:0] run_tokN;
    logic [23:0] run_slot0;
    logic [23:0] run_slotN;
    logic        run_open;

    slot_run_copy_coalescer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles_run);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic copy_desc_t close_run(input logic [6:0] layer, input logic kv);
        copy_desc_t  d;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] p;
        logic [63:0] len;
        s = 64'(shadow_cfg.scalars_per_token);
        c = 64'(kv) * shadow_cfg.layer_count * shadow_cfg.tokens_per_pass * s
          + 64'(layer) * shadow_cfg.tokens_per_pass * s
          + 64'(run_tok0) * s;
        c = c & 64'hFF_FFFF_FFFF;
        p = 64'(kv) * shadow_cfg.page_slots * s + 64'(run_slot0) * s;
        len = (64'(run_slotN) - 64'(run_slot0) + 64'd1) * s * 64'd2;
        d = '0;
        d.bounds_error = (c * 64'd2 + len > 64'(shadow_cfg.cache_total_bytes));
        if (len > 64'hFFFF_FFFF)
        begin
            len = 64'hFFFF_FFFF;
            d.bounds_error = 1'b1;
        end
        d.cache_offset = c[39:0];
        d.paged_offset = p[37:0];
        d.length_bytes = len[31:0];
        d.direction    = shadow_cfg.to_paged;
        return d;
    endfunction

    function automatic void open_run(input logic [15:0] tok, input logic [23:0] slot);
        run_tok0  = tok;
        run_tokN  = tok;
        run_slot0 = slot;
        run_slotN = slot;
        run_open  = 1'b1;
    endfunction

    // Advance the tracker by one token; closed runs land in closed_runs
    function automatic int track_token(input logic [24:0] slot, input logic [6:0] layer,
                                       input logic kv, input logic pass_end);
        logic [15:0] tok;
        int          n;
        tok = tok_count[15:0];
        n = 0;
        if (!slot[24])
        begin
            if (!run_open)
                open_run(tok, slot[23:0]);
            else if (tok != run_tokN + 16'd1 ||
                     {1'b0, slot[23:0]} != {1'b0, run_slotN} + 25'd1)
            begin
                closed_runs[n] = close_run(layer, kv);
                n++;
                open_run(tok, slot[23:0]);
            end
            else
            begin
                run_tokN  = tok;
                run_slotN = slot[23:0];
            end
        end
        if (pass_end)
        begin
            if (run_open)
            begin
                closed_runs[n] = close_run(layer, kv);
                n++;
            end
            run_open  = 1'b0;
            tok_count = '0;
        end
        else
            tok_count = tok_count + 17'd1;
        if (n > 0)
            closed_runs[n-1].last_result = 1'b1;
        return n;
    endfunction

    function automatic logic [63:0] reg_value(input scrc_pkg::reg_idx_t idx);
        case (idx)
            scrc_pkg::REG_SPT: return 64'(shadow_cfg.scalars_per_token);
            scrc_pkg::REG_TPP: return 64'(shadow_cfg.tokens_per_pass);
            scrc_pkg::REG_LC:  return 64'(shadow_cfg.layer_count);
            scrc_pkg::REG_PS:  return 64'(shadow_cfg.page_slots);
            scrc_pkg::REG_CTB: return 64'(shadow_cfg.cache_total_bytes);
            scrc_pkg::REG_DIR: return 64'(shadow_cfg.to_paged);
            default:           return '0;
        endcase
    endfunction

    task automatic apb_cycle(input logic wr, input scrc_pkg::reg_idx_t idx,
                             input logic [63:0] wdata, output logic [63:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 3'b000};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input scrc_pkg::reg_idx_t idx);
        logic [63:0] rd;
        apb_cycle(1'b0, idx, '0, rd);
        if (rd !== reg_value(idx))
        begin
            $display("%0t: register %s expected %h, got %h", $time, idx.name(),
                     reg_value(idx), rd);
            mismatches++;
        end
    endtask

    task automatic program_reg(input scrc_pkg::reg_idx_t idx, input logic [63:0] value);
        logic [63:0] ignored;
        apb_cycle(1'b1, idx, value, ignored);
        case (idx)
            scrc_pkg::REG_SPT: shadow_cfg.scalars_per_token = value[12:0];
            scrc_pkg::REG_TPP: shadow_cfg.tokens_per_pass   = value[16:0];
            scrc_pkg::REG_LC:  shadow_cfg.layer_count       = value[7:0];
            scrc_pkg::REG_PS:  shadow_cfg.page_slots        = value[24:0];
            scrc_pkg::REG_CTB: shadow_cfg.cache_total_bytes = value[39:0];
            scrc_pkg::REG_DIR: shadow_cfg.to_paged          = value[0];
            default: ;
        endcase
        check_reg(idx);
    endtask

    task automatic apply_setting(input logic [12:0] spt, input logic [16:0] tpp,
                                 input logic [7:0] lc, input logic [24:0] ps,
                                 input logic [39:0] ctb, input logic to_paged);
        program_reg(scrc_pkg::REG_SPT, 64'(spt));
        program_reg(scrc_pkg::REG_TPP, 64'(tpp));
        program_reg(scrc_pkg::REG_LC, 64'(lc));
        program_reg(scrc_pkg::REG_PS, 64'(ps));
        program_reg(scrc_pkg::REG_CTB, 64'(ctb));
        program_reg(scrc_pkg::REG_DIR, 64'(to_paged));
    endtask

    task automatic idle(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic send_token(input logic [24:0] slot, input logic [6:0] layer,
                              input logic kv, input logic pass_end,
                              input logic typed, input copy_desc_t want);
        int n;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {layer, slot};
        s_tuser  <= kv;
        s_tlast  <= pass_end;
        do @(posedge clk); while (!s_tready);
        n = track_token(slot, layer, kv, pass_end);
        if (typed)
            pending_copies.push_back(want);
        else
            for (int k = 0; k < n; k++)
                pending_copies.push_back(closed_runs[k]);
    endtask

    // Hold the input until every descriptor is out and the pipeline is empty
    task automatic settle();
        idle(1);
        while (pending_copies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_tokens(input int count);
        logic [24:0] slot;
        logic [24:0] follow;
        logic [6:0]  layer;
        logic        kv;
        logic        pass_end;
        int          burst;
        int          pick;
        follow = SKIP;
        layer  = 7'($urandom);
        kv     = 1'($urandom);
        burst  = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(0, 2) != 0)
                    idle($urandom_range(1, 6));
                burst = $urandom_range(1, 24);
            end
            burst--;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                slot = SKIP;
            else if (pick < 70 && !follow[24])
                slot = follow;
            else if (pick < 78)
                slot = {1'b0, 24'hFFFFFF - 24'($urandom_range(0, 3))};
            else if (pick < 90)
                slot = {1'b0, 24'($urandom)};
            else
                slot = 25'($urandom_range(0, 300));
            if (!slot[24])
                follow = (slot[23:0] == 24'hFFFFFF) ? SKIP : slot + 25'd1;
            pass_end = ($urandom_range(0, 11) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                layer = 7'($urandom);
                kv    = 1'($urandom);
            end
            send_token(slot, layer, kv, pass_end, 1'b0, NO_COPY);
        end
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        copy_desc_t got;
        copy_desc_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tlast, m_tdata};
            if (pending_copies.size() == 0)
            begin
                $display("%0t: descriptor with none pending, expected nothing, got %h",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_copies.pop_front();
                compare_field("cache_offset", 64'(want.cache_offset), 64'(got.cache_offset));
                compare_field("paged_offset", 64'(want.paged_offset), 64'(got.paged_offset));
                compare_field("length_bytes", 64'(want.length_bytes), 64'(got.length_bytes));
                compare_field("direction", 64'(want.direction), 64'(got.direction));
                compare_field("bounds_error", 64'(want.bounds_error), 64'(got.bounds_error));
                compare_field("last_result", 64'(want.last_result), 64'(got.last_result));
            end
        end
    end

    // Receiver: stretches of full rate, light stalls, heavy stalls and toggling
    initial
    begin
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    initial
    begin
        scrc_pkg::reg_idx_t idx;
        shadow_cfg = {scrc_pkg::SPT_RST, scrc_pkg::TPP_RST, scrc_pkg::LC_RST,
                      scrc_pkg::PS_RST, scrc_pkg::CTB_RST, scrc_pkg::DIR_RST};
        tok_count  = '0;
        run_tok0   = '0;
        run_tokN   = '0;
        run_slot0  = '0;
        run_slotN  = '0;
        run_open   = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idx = idx.first();
        do
        begin
            check_reg(idx);
            idx = idx.next();
        end
        while (idx != idx.first());

        foreach (directed_steps[i])
            send_token(directed_steps[i].slot, directed_steps[i].layer, directed_steps[i].kv,
                       directed_steps[i].pass_end, directed_steps[i].typed,
                       directed_steps[i].want);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: apply_setting(13'd0, 17'($urandom_range(1, 65536)),
                                 8'($urandom_range(1, 128)), 25'($urandom_range(1, 16777216)),
                                 40'({$urandom(), $urandom()}), 1'b1);
                1: apply_setting('1, '1, '1, '1, '1, 1'b1);
                2: apply_setting(13'd1, '0, '0, '0, '0, 1'b0);
                default: apply_setting(
                    13'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 4096 : 64)),
                    17'($urandom_range(1, 65536)), 8'($urandom_range(1, 128)),
                    25'($urandom_range(1, 16777216)),
                    40'({$urandom(), $urandom()} >> $urandom_range(0, 56)), 1'($urandom));
            endcase
            random_tokens(167);
            settle();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
